### design/lspc_pkg.sv
// ---------------------------------------------------------------------------
// lspc_pkg: shared definitions for the settled-weight piece counter
// Register indexes, reset values, field widths and the control bundle
// that the sequencer hands to the settle tracker.
// ---------------------------------------------------------------------------
package lspc_pkg;

  // Default values for the top-level parameters
  localparam int DEF_WEIGHT_BITS   = 24;
  localparam int DEF_AVG_FRAC_BITS = 8;

  // Fixed field widths
  localparam int BAND_W      = 24;
  localparam int RUN_W       = 10;
  localparam int BATCH_W     = 8;
  localparam int AVG_W       = 32;
  localparam int TOTAL_W     = 32;
  localparam int COUNT_W     = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_STEADY_BAND    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_SAMPLES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BATCH_SIZE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_AVG    = 3'd4;

  // Register reset values
  localparam logic [BAND_W-1:0]  RST_STEADY_BAND    = 24'd50;
  localparam logic [RUN_W-1:0]   RST_SETTLE_SAMPLES = 10'd10;
  localparam logic [BAND_W-1:0]  RST_NOISE_LIMIT    = 24'd300;
  localparam logic [BATCH_W-1:0] RST_BATCH_SIZE     = 8'd10;
  localparam logic [AVG_W-1:0]   RST_INITIAL_AVG    = 32'd25600;

  // Saturation limits
  localparam logic [RUN_W-1:0]   RUN_MAX   = 10'd1023;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;
  localparam logic [AVG_W-1:0]   AVG_MAX   = 32'hFFFF_FFFF;

  // Control from the sequencer to the settle tracker
  typedef struct packed {
    logic step;         // apply one sample to the tracker state
    logic clear_total;  // batch completed: drop the running total
  } track_ctrl_t;

endpackage

### design/lspc_div.sv
// ---------------------------------------------------------------------------
// lspc_div: shared restoring divider
// One quotient bit per cycle; divides a DIVIDEND_W-bit value by a
// 32-bit non-zero divisor, starting on the start pulse.
// ---------------------------------------------------------------------------
module lspc_div
  import lspc_pkg::*;
#(
  parameter int DIVIDEND_W = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [AVG_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [AVG_W-1:0]      rem;
  logic [AVG_W-1:0]      dsr;
  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVIDEND_W-1:0] quo;

  logic [AVG_W:0] trial;
  logic [AVG_W:0] trial_sub;
  logic           sub_ok;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, dvd[DIVIDEND_W-1]};
    sub_ok    = trial >= {1'b0, dsr};
    trial_sub = trial - {1'b0, dsr};
  end

  // Control: busy flag, step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder, shifting dividend and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= sub_ok ? trial_sub[AVG_W-1:0] : trial[AVG_W-1:0];
      dvd <= dvd << 1;
      quo <= {quo[DIVIDEND_W-2:0], sub_ok};
    end
  end

  assign quotient = quo;

endmodule

### design/lspc_track.sv
// ---------------------------------------------------------------------------
// lspc_track: steadiness and settle tracker
// Holds the previous sample, the settled reference, the steady run and the
// lamp, and adds settled rises to the saturating running total.
// ---------------------------------------------------------------------------
module lspc_track
  import lspc_pkg::*;
#(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  track_ctrl_t            ctrl,
  input  logic [WEIGHT_BITS-1:0] sample,
  input  logic [BAND_W-1:0]      steady_band,
  input  logic [RUN_W-1:0]       settle_samples,
  input  logic [BAND_W-1:0]      noise_limit,
  output logic [TOTAL_W-1:0]     total,
  output logic                   lamp
);

  logic [WEIGHT_BITS-1:0] prev_sample;
  logic [WEIGHT_BITS-1:0] settled_ref;
  logic [RUN_W-1:0]       steady_run;

  logic [WEIGHT_BITS-1:0] prev_sample_next;
  logic [WEIGHT_BITS-1:0] settled_ref_next;
  logic [RUN_W-1:0]       steady_run_next;
  logic [TOTAL_W-1:0]     total_next;
  logic                   lamp_next;

  logic [WEIGHT_BITS-1:0] diff;
  logic [WEIGHT_BITS-1:0] rise;
  logic [WEIGHT_BITS-1:0] fall;
  logic [TOTAL_W:0]       sum;
  logic [RUN_W-1:0]       run_step;
  logic                   steady;
  logic                   is_rise;
  logic                   is_fall;

  // Work out the next tracker state for the sample on offer
  always_comb begin
    diff   = (sample >= prev_sample) ? (sample - prev_sample) : (prev_sample - sample);
    steady = 32'(diff) <= 32'(steady_band);
    rise   = sample - settled_ref;
    fall   = settled_ref - sample;
    is_rise = (sample > settled_ref) && (32'(rise) > 32'(noise_limit));
    is_fall = (settled_ref > sample) && (32'(fall) > 32'(noise_limit));
    sum     = (TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(rise);

    lamp_next        = lamp;
    total_next       = total;
    settled_ref_next = settled_ref;
    prev_sample_next = sample;

    if (steady) begin
      lamp_next = 1'b0;
      run_step  = (steady_run < RUN_MAX) ? steady_run + 1'b1 : steady_run;
    end else begin
      run_step  = '0;
    end
    steady_run_next = run_step;

    // Settled: clamp the run, then take a rise or follow a fall
    if (run_step >= settle_samples) begin
      steady_run_next = settle_samples;
      if (is_rise) begin
        total_next       = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        settled_ref_next = sample;
        lamp_next        = 1'b1;
      end else if (is_fall) begin
        settled_ref_next = sample;
      end
    end
  end

  // Update on a sample; drop the total when a batch completes
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      settled_ref <= '0;
      steady_run  <= '0;
      total       <= '0;
      lamp        <= 1'b0;
    end else if (ctrl.step) begin
      prev_sample <= prev_sample_next;
      settled_ref <= settled_ref_next;
      steady_run  <= steady_run_next;
      total       <= total_next;
      lamp        <= lamp_next;
    end else if (ctrl.clear_total) begin
      total <= '0;
    end
  end

endmodule

### design/load_settle_piece_counter.sv
// ---------------------------------------------------------------------------
// load_settle_piece_counter: settled-weight piece counter
// Tracks load-cell samples, totals settled additions, counts pieces by the
// per-piece average and relearns that average once a batch is complete.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  in        in_valid / in_ready    sample_weight
//  out       out_valid / out_ready  stable_indicator, piece_count,
//                                   accumulated_weight, current_piece_avg,
//                                   avg_relearned
//  cfg       cfg_write_en           cfg_index, cfg_data (no wait, no read-back)
//
//  Each accepted sample runs the shared one-bit-per-cycle divider once for
//  the piece count, and once more for the relearned average when the
//  sample completes a batch.
//  Reset is synchronous; after it the block takes a sample at once.
//  A stalled result holds the output register; the next sample is accepted
//  meanwhile and its result waits until the register is free.
// ---------------------------------------------------------------------------
module load_settle_piece_counter
  import lspc_pkg::*;
#(
  parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS,
  parameter int AVG_FRAC_BITS = DEF_AVG_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WEIGHT_BITS-1:0] sample_weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   stable_indicator,
  output logic [COUNT_W-1:0]     piece_count,
  output logic [TOTAL_W-1:0]     accumulated_weight,
  output logic [AVG_W-1:0]       current_piece_avg,
  output logic                   avg_relearned,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIVIDEND_W = TOTAL_W + AVG_FRAC_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CNT_GO   = 3'd1;
  localparam logic [2:0] S_CNT_WAIT = 3'd2;
  localparam logic [2:0] S_LRN_GO   = 3'd3;
  localparam logic [2:0] S_LRN_WAIT = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state;

  // Configuration registers
  logic [BAND_W-1:0]  steady_band;
  logic [RUN_W-1:0]   settle_samples;
  logic [BAND_W-1:0]  noise_limit;
  logic [BATCH_W-1:0] batch_size;
  logic [AVG_W-1:0]   initial_piece_avg;

  // Learned average and per-sample results
  logic [AVG_W-1:0]   learned_avg;
  logic               avg_learned;
  logic [COUNT_W-1:0] res_count;
  logic               res_relearn;

  logic [AVG_W-1:0]      avg_raw;
  logic [AVG_W-1:0]      avg_use;
  logic [BATCH_W-1:0]    batch_eff;
  logic [TOTAL_W-1:0]    total;
  logic                  lamp;
  track_ctrl_t           track_ctrl;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [AVG_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                  in_txn;
  logic                  out_free;

  assign in_ready = (state == S_IDLE);
  assign in_txn   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Average in use; zero stands for one LSB, as does a zero batch size
  assign avg_raw   = avg_learned ? learned_avg : initial_piece_avg;
  assign avg_use   = (avg_raw == '0) ? AVG_W'(1) : avg_raw;
  assign batch_eff = (batch_size == '0) ? BATCH_W'(1) : batch_size;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      steady_band       <= RST_STEADY_BAND;
      settle_samples    <= RST_SETTLE_SAMPLES;
      noise_limit       <= RST_NOISE_LIMIT;
      batch_size        <= RST_BATCH_SIZE;
      initial_piece_avg <= RST_INITIAL_AVG;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_STEADY_BAND:    steady_band       <= cfg_data[BAND_W-1:0];
        REG_SETTLE_SAMPLES: settle_samples    <= cfg_data[RUN_W-1:0];
        REG_NOISE_LIMIT:    noise_limit       <= cfg_data[BAND_W-1:0];
        REG_BATCH_SIZE:     batch_size        <= cfg_data[BATCH_W-1:0];
        REG_INITIAL_AVG:    initial_piece_avg <= cfg_data[AVG_W-1:0];
        default: ;
      endcase
    end
  end

  // Drive the tracker and the shared divider from the sequencer state
  always_comb begin
    track_ctrl.step        = in_txn;
    track_ctrl.clear_total = (state == S_LRN_WAIT) && div_done;
    div_start    = (state == S_CNT_GO) || (state == S_LRN_GO);
    div_dividend = DIVIDEND_W'(total) << AVG_FRAC_BITS;
    div_divisor  = (state == S_LRN_GO) ? AVG_W'(batch_eff) : avg_use;
  end

  lspc_track #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (track_ctrl),
    .sample         (sample_weight),
    .steady_band    (steady_band),
    .settle_samples (settle_samples),
    .noise_limit    (noise_limit),
    .total          (total),
    .lamp           (lamp)
  );

  lspc_div #(
    .DIVIDEND_W (DIVIDEND_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: count, relearn when the batch is full, then hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      learned_avg <= '0;
      avg_learned <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Offer a new result, or drop the one just taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_txn) begin
            state <= S_CNT_GO;
          end
        end
        S_CNT_GO: begin
          state <= S_CNT_WAIT;
        end
        S_CNT_WAIT: begin
          if (div_done) begin
            if (div_quo >= DIVIDEND_W'(batch_eff)) begin
              state <= S_LRN_GO;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_LRN_GO: begin
          state <= S_LRN_WAIT;
        end
        S_LRN_WAIT: begin
          if (div_done) begin
            if (div_quo > DIVIDEND_W'(AVG_MAX)) begin
              learned_avg <= AVG_MAX;
            end else if (div_quo == '0) begin
              learned_avg <= AVG_W'(1);
            end else begin
              learned_avg <= div_quo[AVG_W-1:0];
            end
            avg_learned <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the count and relearn flag of the sample in flight
  always_ff @(posedge clk) begin
    if (state == S_CNT_WAIT && div_done) begin
      res_count   <= div_quo[COUNT_W-1:0];
      res_relearn <= 1'b0;
    end else if (state == S_LRN_WAIT && div_done) begin
      res_count   <= '0;
      res_relearn <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      stable_indicator   <= lamp;
      piece_count        <= res_count;
      accumulated_weight <= total;
      current_piece_avg  <= avg_use;
      avg_relearned      <= res_relearn;
    end
  end

endmodule

### design/lspc_checker.sv
// ---------------------------------------------------------------------------
// lspc_checker: port-level checks for the piece counter
// Watches the handshakes and result fields of the top level; bound in below.
// ---------------------------------------------------------------------------
module lspc_checker
  import lspc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               stable_indicator,
  input logic [COUNT_W-1:0] piece_count,
  input logic [TOTAL_W-1:0] accumulated_weight,
  input logic [AVG_W-1:0]   current_piece_avg,
  input logic               avg_relearned
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(stable_indicator) && $stable(piece_count) &&
      $stable(accumulated_weight) && $stable(current_piece_avg) &&
      $stable(avg_relearned))
    else $error("result changed while stalled");

  // One sample at a time: no acceptance right after another
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while one is in progress");

  // A relearn clears the count and the total
  a_relearn_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && avg_relearned |-> piece_count == '0 && accumulated_weight == '0)
    else $error("relearn left count or total behind");

  // The average in use is never zero
  a_avg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_piece_avg != '0)
    else $error("zero average reported");

endmodule

bind load_settle_piece_counter lspc_checker u_lspc_checker (.*);
